>>> src/rvdec_pkg.sv
package rvdec_pkg;

    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_MISC   = 7'h0f;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [6:0]  FUNCT7_ALT = 7'b0100000;
    localparam logic [11:0] IMM_EBREAK = 12'h001;

    localparam int INSN_W = 32;
    localparam int IMM_W  = 21;
    localparam int RES_W  = 48;

    typedef enum logic [5:0] {
        MN_ADD, MN_SUB, MN_SLL, MN_SLT, MN_SLTU, MN_XOR, MN_SRL, MN_SRA,
        MN_OR, MN_AND, MN_LB, MN_LH, MN_LW, MN_LBU, MN_LHU, MN_FENCE,
        MN_FENCE_I, MN_ADDI, MN_SLLI, MN_SLTI, MN_SLTIU, MN_XORI, MN_SRLI,
        MN_SRAI, MN_ORI, MN_ANDI, MN_JALR, MN_ECALL, MN_EBREAK, MN_CSRRW,
        MN_CSRRS, MN_CSRRC, MN_CSRRWI, MN_CSRRSI, MN_CSRRCI, MN_AUIPC,
        MN_LUI, MN_SB, MN_SH, MN_SW, MN_BEQ, MN_BNE, MN_BLT, MN_BGE,
        MN_BLTU, MN_BGEU, MN_JAL
    } mnemonic_t;

    typedef enum logic [2:0] {
        FMT_R, FMT_I, FMT_S, FMT_B, FMT_U, FMT_J
    } format_t;

    typedef struct packed {
        logic [IMM_W-1:0] immediate;
        logic [4:0]       src2_reg;
        logic [4:0]       src1_reg;
        logic [4:0]       dest_reg;
        format_t          format;
        mnemonic_t        mnemonic;
        logic             valid_res;
    } dec_t;

endpackage

>>> src/rvdec_decode.sv
module rvdec_decode
(
    input  logic [rvdec_pkg::INSN_W-1:0] insn,
    output rvdec_pkg::dec_t              dec
);

    logic [6:0]                   op;
    logic [2:0]                   f3;
    logic [6:0]                   f7;
    logic                         known;
    rvdec_pkg::mnemonic_t         mn;
    rvdec_pkg::format_t           fmt;
    logic [rvdec_pkg::IMM_W-1:0]  imm;
    logic [rvdec_pkg::IMM_W-1:0]  imm_i;
    logic                         alt;

    assign op    = insn[6:0];
    assign f3    = insn[14:12];
    assign f7    = insn[31:25];
    assign alt   = (f7 == rvdec_pkg::FUNCT7_ALT);
    assign imm_i = {{9{insn[31]}}, insn[31:20]};

    always_comb
    begin
        known = 1'b1;
        mn    = rvdec_pkg::MN_ADD;
        fmt   = rvdec_pkg::FMT_R;
        imm   = '0;
        case (op)
            rvdec_pkg::OP_REG:
            begin
                case (f3)
                    3'd0:    mn = alt ? rvdec_pkg::MN_SUB : rvdec_pkg::MN_ADD;
                    3'd1:    mn = rvdec_pkg::MN_SLL;
                    3'd2:    mn = rvdec_pkg::MN_SLT;
                    3'd3:    mn = rvdec_pkg::MN_SLTU;
                    3'd4:    mn = rvdec_pkg::MN_XOR;
                    3'd5:    mn = alt ? rvdec_pkg::MN_SRA : rvdec_pkg::MN_SRL;
                    3'd6:    mn = rvdec_pkg::MN_OR;
                    default: mn = rvdec_pkg::MN_AND;
                endcase
            end
            rvdec_pkg::OP_LOAD:
            begin
                fmt = rvdec_pkg::FMT_I;
                imm = imm_i;
                case (f3)
                    3'd0:    mn = rvdec_pkg::MN_LB;
                    3'd1:    mn = rvdec_pkg::MN_LH;
                    3'd2:    mn = rvdec_pkg::MN_LW;
                    3'd4:    mn = rvdec_pkg::MN_LBU;
                    3'd5:    mn = rvdec_pkg::MN_LHU;
                    default: known = 1'b0;
                endcase
            end
            rvdec_pkg::OP_MISC:
            begin
                fmt = rvdec_pkg::FMT_I;
                imm = imm_i;
                case (f3)
                    3'd0:    mn = rvdec_pkg::MN_FENCE;
                    3'd1:    mn = rvdec_pkg::MN_FENCE_I;
                    default: known = 1'b0;
                endcase
            end
            rvdec_pkg::OP_IMM:
            begin
                fmt = rvdec_pkg::FMT_I;
                imm = imm_i;
                case (f3)
                    3'd0:    mn = rvdec_pkg::MN_ADDI;
                    3'd1:    mn = rvdec_pkg::MN_SLLI;
                    3'd2:    mn = rvdec_pkg::MN_SLTI;
                    3'd3:    mn = rvdec_pkg::MN_SLTIU;
                    3'd4:    mn = rvdec_pkg::MN_XORI;
                    3'd5:    mn = alt ? rvdec_pkg::MN_SRAI : rvdec_pkg::MN_SRLI;
                    3'd6:    mn = rvdec_pkg::MN_ORI;
                    default: mn = rvdec_pkg::MN_ANDI;
                endcase
            end
            rvdec_pkg::OP_JALR:
            begin
                mn  = rvdec_pkg::MN_JALR;
                fmt = rvdec_pkg::FMT_I;
                imm = imm_i;
            end
            rvdec_pkg::OP_SYSTEM:
            begin
                fmt = rvdec_pkg::FMT_I;
                imm = imm_i;
                case (f3)
                    3'd0:    mn = (insn[31:20] == rvdec_pkg::IMM_EBREAK) ?
                                  rvdec_pkg::MN_EBREAK : rvdec_pkg::MN_ECALL;
                    3'd1:    mn = rvdec_pkg::MN_CSRRW;
                    3'd2:    mn = rvdec_pkg::MN_CSRRS;
                    3'd3:    mn = rvdec_pkg::MN_CSRRC;
                    3'd5:    mn = rvdec_pkg::MN_CSRRWI;
                    3'd6:    mn = rvdec_pkg::MN_CSRRSI;
                    3'd7:    mn = rvdec_pkg::MN_CSRRCI;
                    default: known = 1'b0;
                endcase
            end
            rvdec_pkg::OP_AUIPC:
            begin
                mn  = rvdec_pkg::MN_AUIPC;
                fmt = rvdec_pkg::FMT_U;
                imm = {insn[31], insn[31:12]};
            end
            rvdec_pkg::OP_LUI:
            begin
                mn  = rvdec_pkg::MN_LUI;
                fmt = rvdec_pkg::FMT_U;
                imm = {insn[31], insn[31:12]};
            end
            rvdec_pkg::OP_STORE:
            begin
                fmt = rvdec_pkg::FMT_S;
                imm = {{9{insn[31]}}, insn[31:25], insn[11:7]};
                case (f3)
                    3'd0:    mn = rvdec_pkg::MN_SB;
                    3'd1:    mn = rvdec_pkg::MN_SH;
                    3'd2:    mn = rvdec_pkg::MN_SW;
                    default: known = 1'b0;
                endcase
            end
            rvdec_pkg::OP_BRANCH:
            begin
                fmt = rvdec_pkg::FMT_B;
                imm = {{9{insn[31]}}, insn[7], insn[30:25], insn[11:8], 1'b0};
                case (f3)
                    3'd0:    mn = rvdec_pkg::MN_BEQ;
                    3'd1:    mn = rvdec_pkg::MN_BNE;
                    3'd4:    mn = rvdec_pkg::MN_BLT;
                    3'd5:    mn = rvdec_pkg::MN_BGE;
                    3'd6:    mn = rvdec_pkg::MN_BLTU;
                    3'd7:    mn = rvdec_pkg::MN_BGEU;
                    default: known = 1'b0;
                endcase
            end
            rvdec_pkg::OP_JAL:
            begin
                mn  = rvdec_pkg::MN_JAL;
                fmt = rvdec_pkg::FMT_J;
                imm = {insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
            end
            default:
                known = 1'b0;
        endcase
    end

    always_comb
    begin
        dec = '0;
        if (known)
        begin
            dec.valid_res = 1'b1;
            dec.mnemonic  = mn;
            dec.format    = fmt;
            dec.immediate = imm;
            if (fmt == rvdec_pkg::FMT_R || fmt == rvdec_pkg::FMT_I ||
                fmt == rvdec_pkg::FMT_U || fmt == rvdec_pkg::FMT_J)
                dec.dest_reg = insn[11:7];
            if (fmt == rvdec_pkg::FMT_R || fmt == rvdec_pkg::FMT_I ||
                fmt == rvdec_pkg::FMT_S || fmt == rvdec_pkg::FMT_B)
                dec.src1_reg = insn[19:15];
            if (fmt == rvdec_pkg::FMT_R || fmt == rvdec_pkg::FMT_S ||
                fmt == rvdec_pkg::FMT_B)
                dec.src2_reg = insn[24:20];
        end
    end

endmodule

>>> src/rv32i_instruction_decoder.sv
// RV32I instruction decoder. Each 32-bit instruction word on the slave stream
// yields one decoded word on the master stream. Two register stages (input
// word, decoded result) with the decode logic between them; a word can be
// taken every cycle while the output is not stalled, the input word is
// registered in insn_reg and the decoded result in res_reg before m_tvalid
// rises, and output backpressure stalls both stages. Unknown opcode/funct3
// gives an all-zero result word (valid_res = 0).
module rv32i_instruction_decoder
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [31:0] instruction_word
    input  logic [rvdec_pkg::INSN_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [0] valid_res, [6:1] mnemonic, [9:7] format, [14:10] dest_reg,
    // [19:15] src1_reg, [24:20] src2_reg, [45:25] immediate, [47:46] zero
    output logic [rvdec_pkg::RES_W-1:0]  m_tdata
);

    logic                         in_valid_reg;
    logic [rvdec_pkg::INSN_W-1:0] insn_reg;
    logic                         out_valid_reg;
    rvdec_pkg::dec_t              res_reg;
    rvdec_pkg::dec_t              res_next;
    logic                         out_ready;
    logic                         in_ready;

    assign out_ready = !out_valid_reg || m_tready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign s_tready  = in_ready;

    rvdec_decode u_decode
    (
        .insn (insn_reg),
        .dec  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= s_tvalid;
            if (out_ready)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_tvalid)
            insn_reg <= s_tdata;
        if (out_ready && in_valid_reg)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, res_reg};

endmodule
